[src/afp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package afp_pkg;

  // One 16-byte AES block, index 0 is byte 0 of the block.
  typedef logic [15:0][7:0] block_t;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CfgKeyHigh = 2'd0,
    CfgKeyLow  = 2'd1,
    CfgWidth   = 2'd2,
    CfgNone    = 2'd3
  } cfg_idx_e;

  localparam int unsigned Rounds    = 4;
  localparam int unsigned AesRounds = 10;
  localparam int unsigned DataW     = 64;
  localparam int unsigned WidthW    = 7;
  localparam int unsigned HalfW     = 6;

  localparam logic [7:0] RCON [10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX[x];
  endfunction

  // Multiply by two in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

`default_nettype wire

[src/afp_round.sv]
`timescale 1ns / 1ps
`default_nettype none

module afp_round (
  input  afp_pkg::block_t state_i,
  input  afp_pkg::block_t key_i,
  input  logic [7:0]      rcon_i,
  input  logic            last_i,
  output afp_pkg::block_t state_o,
  output afp_pkg::block_t key_o
);

  afp_pkg::block_t sb;
  afp_pkg::block_t mc;
  afp_pkg::block_t nk;
  logic [3:0][7:0] w;
  logic [7:0] a0, a1, a2, a3, e;

  // Next round key from the previous one.
  always_comb begin
    w[0] = afp_pkg::sbox(key_i[13]) ^ rcon_i;
    w[1] = afp_pkg::sbox(key_i[14]);
    w[2] = afp_pkg::sbox(key_i[15]);
    w[3] = afp_pkg::sbox(key_i[12]);
    for (int j = 0; j < 4; j++) begin
      nk[j]      = key_i[j] ^ w[j];
      nk[4 + j]  = key_i[4 + j] ^ nk[j];
      nk[8 + j]  = key_i[8 + j] ^ nk[4 + j];
      nk[12 + j] = key_i[12 + j] ^ nk[8 + j];
    end
  end

  // SubBytes and ShiftRows; byte index is column * 4 + row.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        sb[c * 4 + j] = afp_pkg::sbox(state_i[((c + j) % 4) * 4 + j]);
      end
    end
  end

  // MixColumns, skipped in the final round.
  always_comb begin
    a0 = '0;
    a1 = '0;
    a2 = '0;
    a3 = '0;
    e  = '0;
    mc = sb;
    if (!last_i) begin
      for (int c = 0; c < 4; c++) begin
        a0 = sb[c * 4];
        a1 = sb[c * 4 + 1];
        a2 = sb[c * 4 + 2];
        a3 = sb[c * 4 + 3];
        e  = a0 ^ a1 ^ a2 ^ a3;
        mc[c * 4]     = a0 ^ e ^ afp_pkg::xtime(a0 ^ a1);
        mc[c * 4 + 1] = a1 ^ e ^ afp_pkg::xtime(a1 ^ a2);
        mc[c * 4 + 2] = a2 ^ e ^ afp_pkg::xtime(a2 ^ a3);
        mc[c * 4 + 3] = a3 ^ e ^ afp_pkg::xtime(a3 ^ a0);
      end
    end
  end

  assign state_o = mc ^ nk;
  assign key_o   = nk;

endmodule

`default_nettype wire

[src/afp_aes_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module afp_aes_lane (
  input  logic            clk_i,
  input  logic            en_i,
  input  afp_pkg::block_t pt_i,
  input  afp_pkg::block_t key_i,
  output afp_pkg::block_t ct_o
);

  afp_pkg::block_t state_q [afp_pkg::AesRounds + 1];
  afp_pkg::block_t key_q   [afp_pkg::AesRounds + 1];
  afp_pkg::block_t state_d [afp_pkg::AesRounds + 1];
  afp_pkg::block_t key_d   [afp_pkg::AesRounds + 1];

  // Initial AddRoundKey in the entry stage.
  assign state_d[0] = pt_i ^ key_i;
  assign key_d[0]   = key_i;

  // One AES round per stage; the round key is expanded alongside the data.
  for (genvar k = 1; k <= afp_pkg::AesRounds; k++) begin : g_round
    afp_round u_round (
      .state_i (state_q[k - 1]),
      .key_i   (key_q[k - 1]),
      .rcon_i  (afp_pkg::RCON[k - 1]),
      .last_i  (1'(k == afp_pkg::AesRounds)),
      .state_o (state_d[k]),
      .key_o   (key_d[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign ct_o = state_q[afp_pkg::AesRounds];

endmodule

`default_nettype wire

[src/aes_feistel_small_domain_prp_unit.sv]
// Keyed permutation of a value over a domain of domain_width bits, built from
// four AES-128 encryptions of the low half of the value, one per round key.
// Input values arrive on the s_axis channel and permuted values leave on the
// m_axis channel, one result per input, in order.
// The configuration channel writes key_high (index 0), key_low (index 1) and
// domain_width (index 2); other indexes are dropped. It is always ready and
// must only be used while no transaction is in flight.
// An item passes twelve register stages: one entry stage with the initial key
// addition, ten AES round stages (round key expansion runs alongside in the
// same stages) and one output stage. Output valid rises when the item reaches
// the output stage. Throughput is one value per cycle while the receiver does
// not stall; the four AES lanes run in parallel.
// When the receiver stalls, the whole pipeline holds and s_axis_tready drops;
// it stays high while the output register is empty or being drained.
// Reset empties the pipeline and sets the key to zero and the width to 64.
`timescale 1ns / 1ps
`default_nettype none

module aes_feistel_small_domain_prp_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [63:0] value_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // [63:0] value_out
);

  localparam int unsigned Stages = afp_pkg::AesRounds + 1;

  logic [63:0] key_high_q;
  logic [63:0] key_low_q;
  logic [afp_pkg::WidthW-1:0] width_q;

  logic [Stages:0] vld_q;
  logic            en;

  logic [afp_pkg::WidthW-1:0] width_sat;
  logic [afp_pkg::HalfW-1:0]  half;
  logic [63:0] dom_mask;
  logic [63:0] right;
  afp_pkg::block_t key_base;
  afp_pkg::block_t pt;
  afp_pkg::block_t ct [afp_pkg::Rounds];

  logic [63:0]               val_q  [Stages];
  logic [63:0]               mask_q [Stages];
  logic [afp_pkg::HalfW-1:0] half_q [Stages];

  logic [63:0] f;
  logic [63:0] out_d;
  logic [63:0] out_q;
  logic [63:0] out_mask_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      width_q    <= afp_pkg::WidthW'(64);
    end else if (cfg_valid_i) begin
      case (afp_pkg::cfg_idx_e'(cfg_index_i))
        afp_pkg::CfgKeyHigh: key_high_q <= cfg_data_i;
        afp_pkg::CfgKeyLow:  key_low_q  <= cfg_data_i;
        afp_pkg::CfgWidth:   width_q    <= cfg_data_i[afp_pkg::WidthW-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless the output holds an untaken result.
  assign en            = !vld_q[Stages] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-1:0], s_axis_tvalid};
    end
  end

  // Domain width, half width and the right half of the input.
  always_comb begin
    width_sat = (width_q > afp_pkg::WidthW'(64)) ? afp_pkg::WidthW'(64) : width_q;
    half      = width_sat[afp_pkg::HalfW:1];
    dom_mask  = width_sat[afp_pkg::HalfW] ? '1 :
                ((64'd1 << width_sat[afp_pkg::HalfW-1:0]) - 64'd1);
    right     = s_axis_tdata & ((64'd1 << half) - 64'd1);
  end

  // Key bytes and plaintext block: eight zero bytes, then R little-endian.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key_base[i]     = key_high_q[63 - 8 * i -: 8];
      key_base[8 + i] = key_low_q[63 - 8 * i -: 8];
      pt[i]           = 8'h00;
      pt[8 + i]       = right[8 * i +: 8];
    end
  end

  // One AES lane per round key; round r flips the low bits of key byte 15.
  for (genvar r = 0; r < afp_pkg::Rounds; r++) begin : g_lane
    afp_pkg::block_t lane_key;

    always_comb begin
      lane_key     = key_base;
      lane_key[15] = key_base[15] ^ 8'(r);
    end

    afp_aes_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .pt_i  (pt),
      .key_i (lane_key),
      .ct_o  (ct[r])
    );
  end

  // Value, mask and half width travel beside the AES lanes.
  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q[0]  <= s_axis_tdata;
      mask_q[0] <= dom_mask;
      half_q[0] <= half;
      for (int k = 1; k < Stages; k++) begin
        val_q[k]  <= val_q[k - 1];
        mask_q[k] <= mask_q[k - 1];
        half_q[k] <= half_q[k - 1];
      end
    end
  end

  // Combine the four round outputs; the halves are never swapped, so all
  // rounds XOR into the left part of the same block.
  always_comb begin
    f = '0;
    for (int r = 0; r < afp_pkg::Rounds; r++) begin
      for (int i = 0; i < 8; i++) begin
        f[8 * i +: 8] = f[8 * i +: 8] ^ ct[r][8 + i];
      end
    end
    out_d = (val_q[Stages-1] ^ (f << half_q[Stages-1])) & mask_q[Stages-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q      <= out_d;
      out_mask_q <= mask_q[Stages-1];
    end
  end

  assign m_axis_tvalid = vld_q[Stages];
  assign m_axis_tdata  = out_q;

  // A stalled pipeline keeps its occupancy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline occupancy changed during a stall");

  // Results never carry bits above the domain width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata & ~out_mask_q) == 64'd0))
    else $error("result has bits above the domain width");

  // An accepted input always occupies the entry stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted input lost at the entry stage");

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;  // [63:0] value_in
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;  // [63:0] value_out

  aes_feistel_small_domain_prp_unit uut (.*);

  // Local copy of the configuration registers.
  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;
  logic [6:0]  dom_width_q;

  logic [63:0] expected_perm_q[$];
  int          mismatch_cnt;
  int          result_cnt;
  int          send_idle_pct;
  int          recv_idle_pct;

  // Clock with a 4 ns period.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Table lookup of the AES S-box, kept apart from the package helper.
  function automatic logic [7:0] sub_byte(input logic [7:0] x);
    logic [7:0] tbl [256];
    tbl = afp_pkg::SBOX;
    return tbl[x];
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return (x << 1) ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // AES-128 encryption of one block, byte 0 first.
  function automatic afp_pkg::block_t aes128_encrypt(input afp_pkg::block_t key,
                                                     input afp_pkg::block_t pt);
    logic [7:0] rk [176];
    logic [7:0] w [4];
    logic [7:0] tmp;
    afp_pkg::block_t st;
    afp_pkg::block_t nx;
    logic [7:0] a0, a1, a2, a3, e;
    for (int i = 0; i < 16; i++) rk[i] = key[i];
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i - 4 + j];
      if (i % 16 == 0) begin
        tmp  = w[0];
        w[0] = sub_byte(w[1]) ^ afp_pkg::RCON[i / 16 - 1];
        w[1] = sub_byte(w[2]);
        w[2] = sub_byte(w[3]);
        w[3] = sub_byte(tmp);
      end
      for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) st[i] = pt[i] ^ rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      // SubBytes and ShiftRows, then MixColumns except in the last round.
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) nx[c * 4 + j] = sub_byte(st[((c + j) % 4) * 4 + j]);
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = nx[c * 4]; a1 = nx[c * 4 + 1]; a2 = nx[c * 4 + 2]; a3 = nx[c * 4 + 3];
          e  = a0 ^ a1 ^ a2 ^ a3;
          nx[c * 4]     = a0 ^ e ^ gf_double(a0 ^ a1);
          nx[c * 4 + 1] = a1 ^ e ^ gf_double(a1 ^ a2);
          nx[c * 4 + 2] = a2 ^ e ^ gf_double(a2 ^ a3);
          nx[c * 4 + 3] = a3 ^ e ^ gf_double(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = nx[i] ^ rk[rnd * 16 + i];
    end
    return st;
  endfunction

  // Predicts the permuted value under the current key and width.
  function automatic logic [63:0] permute_value(input logic [63:0] value);
    int unsigned wd;
    int unsigned hw;
    afp_pkg::block_t key;
    afp_pkg::block_t rkey;
    afp_pkg::block_t pt;
    afp_pkg::block_t ct;
    logic [63:0] blk;
    logic [63:0] rhalf;
    logic [63:0] f;
    wd = (dom_width_q > 64) ? 64 : dom_width_q;
    if (wd == 0) return 64'd0;
    hw  = wd / 2;
    blk = value;
    for (int i = 0; i < 8; i++) begin
      key[i]     = key_hi_q[63 - 8 * i -: 8];
      key[8 + i] = key_lo_q[63 - 8 * i -: 8];
    end
    for (int r = 0; r < afp_pkg::Rounds; r++) begin
      rkey     = key;
      rkey[15] = rkey[15] ^ 8'(r);
      rhalf    = blk & ((64'd1 << hw) - 64'd1);
      pt       = '0;
      for (int i = 0; i < 8; i++) pt[8 + i] = rhalf[8 * i +: 8];
      ct = aes128_encrypt(rkey, pt);
      f  = '0;
      for (int i = 0; i < 8; i++) f[8 * i +: 8] = ct[8 + i];
      blk = blk ^ (f << hw);
    end
    if (wd < 64) blk = blk & ((64'd1 << wd) - 64'd1);
    return blk;
  endfunction

  // Writes one configuration register and mirrors it locally.
  task automatic write_reg(input afp_pkg::cfg_idx_e idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      afp_pkg::CfgKeyHigh: key_hi_q = data;
      afp_pkg::CfgKeyLow:  key_lo_q = data;
      afp_pkg::CfgWidth:   dom_width_q = data[6:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Sends one value; the expectation is queued at the accepting edge.
  // Valid stays high after the transaction so that values can follow back to
  // back; an idle gap or a drain lowers it.
  task automatic send_value(input logic [63:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_perm_q.push_back(permute_value(value));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_perm_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Checks each output transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_cnt++;
      if (expected_perm_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected output %h", m_axis_tdata);
      end else begin
        logic [63:0] exp_v;
        exp_v = expected_perm_q.pop_front();
        if (m_axis_tdata !== exp_v) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("value_out mismatch: expected %h, got %h", exp_v, m_axis_tdata);
        end
      end
    end
  end

  // Reset-default key and width, field extremes, small widths, then a saturated width and an unused index.
  task automatic test_directed();
    send_value(64'd0);
    send_value('1);
    send_value(64'h8000_0000_0000_0001);
    wait_drained();
    write_reg(afp_pkg::CfgKeyHigh, '1);
    write_reg(afp_pkg::CfgKeyLow, '1);
    send_value(64'h0123_4567_89ab_cdef);
    send_value('1);
    wait_drained();
    // Zero width forces a zero result; width one uses an empty right half.
    for (int wd = 0; wd <= 3; wd++) begin
      write_reg(afp_pkg::CfgWidth, 64'(wd));
      send_value('1);
      send_value(64'd0);
      send_value(64'h5555_5555_5555_5555);
      wait_drained();
    end
    // Width codes above 64 saturate; the unused index must be dropped.
    write_reg(afp_pkg::CfgWidth, 64'd127);
    write_reg(afp_pkg::CfgNone, 64'hdead_beef_0000_0000);
    send_value(64'hfedc_ba98_7654_3210);
    send_value(64'd1);
    wait_drained();
  endtask

  // Random values over random key and width settings.
  task automatic test_random(input int phase_items);
    logic [63:0] v;
    for (int n = 0; n < phase_items; n++) begin
      if (n % 75 == 0) begin
        wait_drained();
        write_reg(afp_pkg::CfgKeyHigh, {$urandom, $urandom});
        write_reg(afp_pkg::CfgKeyLow, {$urandom, $urandom});
        case ($urandom_range(3))
          0: write_reg(afp_pkg::CfgWidth, 64'd64);
          1: write_reg(afp_pkg::CfgWidth, 64'($urandom_range(2)));
          default: write_reg(afp_pkg::CfgWidth, 64'($urandom_range(127)));
        endcase
      end
      v = {$urandom, $urandom};
      send_value(v);
    end
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = afp_pkg::CfgKeyHigh;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    key_hi_q      = '0;
    key_lo_q      = '0;
    dom_width_q   = 7'd64;
    mismatch_cnt  = 0;
    result_cnt    = 0;
    send_idle_pct = 9;
    recv_idle_pct = 53;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(450);
    send_idle_pct = 53;
    recv_idle_pct = 9;
    test_random(450);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(450);

    $display("Covered %0d results over zero, one, small, full and saturated widths,",
             result_cnt);
    $display("random keys and both idle patterns plus full-rate streaming.");
    if (mismatch_cnt == 0 && expected_perm_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
